// ===== design/sha1mh_pkg.sv =====
// Shared types, constants and helper functions for the SHA-1 message hash block.
package sha1mh_pkg;

    // Operation codes carried in the op field of an input beat
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int NUM_HASH_WORDS = 5;
    localparam int NUM_ROUNDS     = 80;
    localparam int BLOCK_WORDS    = 16;
    localparam int BLOCK_BYTES    = 64;
    localparam int LEN_START_BYTE = 56;

    localparam logic [31:0] K_ROUND_0 = 32'h5A82_7999;
    localparam logic [31:0] K_ROUND_1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_ROUND_2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K_ROUND_3 = 32'hCA62_C1D6;

    localparam logic [31:0] H_INIT_0 = 32'h6745_2301;
    localparam logic [31:0] H_INIT_1 = 32'hEFCD_AB89;
    localparam logic [31:0] H_INIT_2 = 32'h98BA_DCFE;
    localparam logic [31:0] H_INIT_3 = 32'h1032_5476;
    localparam logic [31:0] H_INIT_4 = 32'hC3D2_E1F0;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // Round groups, each with its own boolean function and constant
    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY_LO,
        PH_MAJORITY,
        PH_PARITY_HI
    } phase_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } digest_beat_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       write_byte;
        logic       pad_first;
        logic       pad_second;
        logic       load_work;
        logic       round;
        phase_t     phase;
        logic       fold;
        logic       emit;
        logic [2:0] emit_idx;
        logic       restart;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pos_last;
        logic pos_high;
        logic out_free;
    } dp_status_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        rotl5 = {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        rotl30 = {x[1:0], x[31:2]};
    endfunction

endpackage

// ===== design/sha1_message_hash.sv =====
// Top level of the SHA-1 message hash: controller plus datapath.
//
//   channel  handshake                   beat fields
//   msg      msg_valid / msg_stall       op, data_byte
//   digest   digest_valid / digest_stall digest_word, word_last
//
// An absorb beat that does not fill a block causes no stall; the beat that fills a 64-byte
// block stalls for load, the rounds of the single shared round unit, and fold.
// A finish beat runs one or two block compressions, then five digest beats
// leave through one output register, one a cycle when digest_stall stays low.
// Reset restores the initial hash words and a zero byte count; no clearing pass.
// msg_stall is high from a block-filling beat until the fold, and from a finish beat
// until the last digest word is in the output register; digest stalls only delay emission.
module sha1_message_hash (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     msg_valid,
    output logic                     msg_stall,
    input  sha1mh_pkg::msg_beat_t    msg,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output sha1mh_pkg::digest_beat_t digest
);

    sha1mh_pkg::dp_cmd_t    cmd;
    sha1mh_pkg::dp_status_t status;

    sha1mh_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_op    (msg.op),
        .msg_stall (msg_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sha1mh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (msg.data_byte),
        .status       (status),
        .digest_stall (digest_stall),
        .digest_valid (digest_valid),
        .digest       (digest)
    );

endmodule

// ===== design/sha1mh_datapath.sv =====
// Datapath: block buffer, message schedule window, working and hash words, output register.
module sha1mh_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha1mh_pkg::dp_cmd_t      cmd,
    input  logic [7:0]               data_byte,
    output sha1mh_pkg::dp_status_t   status,
    input  logic                     digest_stall,
    output logic                     digest_valid,
    output sha1mh_pkg::digest_beat_t digest
);

    logic [15:0][31:0] w_reg;
    logic [15:0][31:0] w_next;
    logic [4:0][31:0]  h_reg;
    logic [4:0][31:0]  h_next;
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]       a_next, b_next, c_next, d_next, e_next;
    logic [60:0]       count_reg;
    logic [60:0]       count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    sha1mh_pkg::digest_beat_t out_reg;
    sha1mh_pkg::digest_beat_t out_next;

    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] temp;

    assign pos     = count_reg[5:0];
    assign bit_len = {count_reg, 3'b000};

    assign status.pos_last = (pos == 6'd63);
    assign status.pos_high = (pos >= 6'(sha1mh_pkg::LEN_START_BYTE));
    assign status.out_free = !out_valid_reg || !digest_stall;

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    // Select round function and constant
    always_comb
    begin
        unique case (cmd.phase)
            sha1mh_pkg::PH_CHOOSE:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = sha1mh_pkg::K_ROUND_0;
            end
            sha1mh_pkg::PH_PARITY_LO:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1mh_pkg::K_ROUND_1;
            end
            sha1mh_pkg::PH_MAJORITY:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = sha1mh_pkg::K_ROUND_2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1mh_pkg::K_ROUND_3;
            end
        endcase
    end

    assign temp = sha1mh_pkg::rotl5(a_reg) + f_val + e_reg + k_val + w_reg[0];

    // Block buffer: byte writes, padding fills and schedule shifting
    always_comb
    begin
        w_next = w_reg;
        if (cmd.round)
        begin
            for (int j = 0; j < sha1mh_pkg::BLOCK_WORDS - 1; j++)
            begin
                w_next[j] = w_reg[j + 1];
            end
            w_next[sha1mh_pkg::BLOCK_WORDS - 1] =
                sha1mh_pkg::rotl1(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]);
        end
        else
        begin
            for (int i = 0; i < sha1mh_pkg::BLOCK_BYTES; i++)
            begin
                if (cmd.write_byte && (pos == 6'(i)))
                begin
                    w_next[i / 4][31 - 8 * (i % 4) -: 8] = data_byte;
                end
                else if (cmd.pad_first)
                begin
                    if (pos == 6'(i))
                    begin
                        w_next[i / 4][31 - 8 * (i % 4) -: 8] = sha1mh_pkg::PAD_MARK;
                    end
                    else if (pos < 6'(i))
                    begin
                        if (!status.pos_high && (i >= sha1mh_pkg::LEN_START_BYTE))
                        begin
                            w_next[i / 4][31 - 8 * (i % 4) -: 8] =
                                bit_len[63 - 8 * (i - sha1mh_pkg::LEN_START_BYTE) -: 8];
                        end
                        else
                        begin
                            w_next[i / 4][31 - 8 * (i % 4) -: 8] = 8'h00;
                        end
                    end
                end
                else if (cmd.pad_second)
                begin
                    if (i >= sha1mh_pkg::LEN_START_BYTE)
                    begin
                        w_next[i / 4][31 - 8 * (i % 4) -: 8] =
                            bit_len[63 - 8 * (i - sha1mh_pkg::LEN_START_BYTE) -: 8];
                    end
                    else
                    begin
                        w_next[i / 4][31 - 8 * (i % 4) -: 8] = 8'h00;
                    end
                end
            end
        end
    end

    // Working words: load from hash words, advance one round
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        if (cmd.load_work)
        begin
            a_next = h_reg[0];
            b_next = h_reg[1];
            c_next = h_reg[2];
            d_next = h_reg[3];
            e_next = h_reg[4];
        end
        else if (cmd.round)
        begin
            a_next = temp;
            b_next = a_reg;
            c_next = sha1mh_pkg::rotl30(b_reg);
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    // Hash words and byte count: fold after a block, restart after a digest
    always_comb
    begin
        h_next     = h_reg;
        count_next = count_reg;
        if (cmd.fold)
        begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            h_next[4] = h_reg[4] + e_reg;
        end
        else if (cmd.restart)
        begin
            h_next[0] = sha1mh_pkg::H_INIT_0;
            h_next[1] = sha1mh_pkg::H_INIT_1;
            h_next[2] = sha1mh_pkg::H_INIT_2;
            h_next[3] = sha1mh_pkg::H_INIT_3;
            h_next[4] = sha1mh_pkg::H_INIT_4;
        end
        if (cmd.restart)
        begin
            count_next = '0;
        end
        else if (cmd.write_byte)
        begin
            count_next = count_reg + 61'd1;
        end
    end

    // Output register: load a digest word, drop it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !digest_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next        = 1'b1;
            out_next.digest_word  = h_reg[cmd.emit_idx];
            out_next.word_last    = (cmd.emit_idx == 3'(sha1mh_pkg::NUM_HASH_WORDS - 1));
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0]      <= sha1mh_pkg::H_INIT_0;
            h_reg[1]      <= sha1mh_pkg::H_INIT_1;
            h_reg[2]      <= sha1mh_pkg::H_INIT_2;
            h_reg[3]      <= sha1mh_pkg::H_INIT_3;
            h_reg[4]      <= sha1mh_pkg::H_INIT_4;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            h_reg         <= h_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload state
    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        out_reg <= out_next;
    end

endmodule

// ===== design/sha1mh_control.sv =====
// Controller: sequences byte absorb, padding, 80 compression rounds and digest emission.
module sha1mh_control (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    input  logic                   msg_op,
    output logic                   msg_stall,
    input  sha1mh_pkg::dp_status_t status,
    output sha1mh_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD2,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       final_reg, final_next;
    logic       second_reg, second_next;
    logic       accept;

    assign msg_stall = (state_reg != ST_IDLE);
    assign accept    = msg_valid && !msg_stall;

    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        final_next  = final_reg;
        second_next = second_reg;
        cmd         = '0;

        // Round group from the round counter
        if (round_reg < 7'd20)
        begin
            cmd.phase = sha1mh_pkg::PH_CHOOSE;
        end
        else if (round_reg < 7'd40)
        begin
            cmd.phase = sha1mh_pkg::PH_PARITY_LO;
        end
        else if (round_reg < 7'd60)
        begin
            cmd.phase = sha1mh_pkg::PH_MAJORITY;
        end
        else
        begin
            cmd.phase = sha1mh_pkg::PH_PARITY_HI;
        end
        cmd.emit_idx = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    round_next = '0;
                    if (msg_op == sha1mh_pkg::OP_ABSORB)
                    begin
                        cmd.write_byte = 1'b1;
                        final_next     = 1'b0;
                        second_next    = 1'b0;
                        if (status.pos_last)
                        begin
                            cmd.load_work = 1'b1;
                            state_next    = ST_ROUND;
                        end
                    end
                    else
                    begin
                        cmd.pad_first = 1'b1;
                        cmd.load_work = 1'b1;
                        final_next    = 1'b1;
                        second_next   = status.pos_high;
                        state_next    = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(sha1mh_pkg::NUM_ROUNDS - 1))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (second_reg)
                begin
                    state_next = ST_PAD2;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_PAD2:
            begin
                cmd.pad_second = 1'b1;
                cmd.load_work  = 1'b1;
                round_next     = '0;
                second_next    = 1'b0;
                state_next     = ST_ROUND;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(sha1mh_pkg::NUM_HASH_WORDS - 1))
                    begin
                        cmd.restart = 1'b1;
                        final_next  = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            round_reg  <= '0;
            idx_reg    <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            final_reg  <= final_next;
            second_reg <= second_next;
        end
    end

endmodule

// ===== verif/tb_sha1_message_hash.sv =====
// Self-checking testbench for sha1_message_hash: byte-serial messages in, checked digest words out.
module tb_sha1_message_hash;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int MIN_ITEMS     = 200;

    // Digest predictor and store of expected digest words
    class digest_scoreboard;
        logic [31:0]  hash_state [sha1mh_pkg::NUM_HASH_WORDS];
        logic [7:0]   block_bytes [sha1mh_pkg::BLOCK_BYTES];
        logic [60:0]  msg_bytes;
        sha1mh_pkg::digest_beat_t pending_words [$];
        int           mismatches;

        function new();
            mismatches = 0;
            foreach (block_bytes[i]) block_bytes[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            hash_state[0] = sha1mh_pkg::H_INIT_0;
            hash_state[1] = sha1mh_pkg::H_INIT_1;
            hash_state[2] = sha1mh_pkg::H_INIT_2;
            hash_state[3] = sha1mh_pkg::H_INIT_3;
            hash_state[4] = sha1mh_pkg::H_INIT_4;
            msg_bytes = '0;
        endfunction

        function logic [31:0] rol(input logic [31:0] x, input int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        // Run the 80 rounds over the current block and fold into the hash state
        function void compress();
            logic [31:0] w [sha1mh_pkg::NUM_ROUNDS];
            logic [31:0] a, b, c, d, e, f, k, t;
            for (int i = 0; i < sha1mh_pkg::BLOCK_WORDS; i++)
                w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
            for (int i = sha1mh_pkg::BLOCK_WORDS; i < sha1mh_pkg::NUM_ROUNDS; i++)
                w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            a = hash_state[0];
            b = hash_state[1];
            c = hash_state[2];
            d = hash_state[3];
            e = hash_state[4];
            for (int i = 0; i < sha1mh_pkg::NUM_ROUNDS; i++)
            begin
                if (i < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = sha1mh_pkg::K_ROUND_0;
                end
                else if (i < 40)
                begin
                    f = b ^ c ^ d;
                    k = sha1mh_pkg::K_ROUND_1;
                end
                else if (i < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = sha1mh_pkg::K_ROUND_2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = sha1mh_pkg::K_ROUND_3;
                end
                t = rol(a, 5) + f + e + k + w[i];
                e = d;
                d = c;
                c = rol(b, 30);
                b = a;
                a = t;
            end
            hash_state[0] += a;
            hash_state[1] += b;
            hash_state[2] += c;
            hash_state[3] += d;
            hash_state[4] += e;
        endfunction

        // Apply one accepted message beat; a finish pads, compresses and queues the digest
        function void note_beat(input sha1mh_pkg::msg_beat_t beat);
            int           pos;
            logic [63:0]  bit_len;
            sha1mh_pkg::digest_beat_t word;
            pos = int'(msg_bytes[5:0]);
            if (beat.op == sha1mh_pkg::OP_ABSORB)
            begin
                block_bytes[pos] = beat.data_byte;
                msg_bytes = msg_bytes + 61'd1;
                if (pos == sha1mh_pkg::BLOCK_BYTES - 1)
                    compress();
            end
            else
            begin
                bit_len = {msg_bytes, 3'b000};
                block_bytes[pos] = sha1mh_pkg::PAD_MARK;
                for (int i = pos + 1; i < sha1mh_pkg::BLOCK_BYTES; i++)
                    block_bytes[i] = 8'h00;
                // no room left for the length: spill into a second block
                if (pos >= sha1mh_pkg::LEN_START_BYTE)
                begin
                    compress();
                    for (int i = 0; i < sha1mh_pkg::LEN_START_BYTE; i++)
                        block_bytes[i] = 8'h00;
                end
                for (int i = 0; i < 8; i++)
                    block_bytes[sha1mh_pkg::LEN_START_BYTE + i] = bit_len[63 - 8*i -: 8];
                compress();
                for (int i = 0; i < sha1mh_pkg::NUM_HASH_WORDS; i++)
                begin
                    word.digest_word = hash_state[i];
                    word.word_last   = (i == sha1mh_pkg::NUM_HASH_WORDS - 1);
                    pending_words.push_back(word);
                end
                restart();
            end
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one accepted digest beat with the oldest expected word
        task check_digest(input sha1mh_pkg::digest_beat_t got);
            sha1mh_pkg::digest_beat_t want;
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digest beat %08h last=%0b",
                                          got.digest_word, got.word_last));
                return;
            end
            want = pending_words.pop_front();
            if (got.digest_word !== want.digest_word)
                report_mismatch($sformatf("digest_word got %08h want %08h",
                                          got.digest_word, want.digest_word));
            if (got.word_last !== want.word_last)
                report_mismatch($sformatf("word_last got %0b want %0b",
                                          got.word_last, want.word_last));
        endtask

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n = 1'b0;
    logic         msg_valid = 1'b0;
    logic         msg_stall;
    sha1mh_pkg::msg_beat_t    msg = '0;
    logic         digest_valid;
    logic         digest_stall = 1'b0;
    sha1mh_pkg::digest_beat_t digest;

    digest_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int messages_sent  = 0;
    int cycle_count    = 0;

    sha1_message_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the digest channel at random
    always @(posedge clk)
        digest_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Check every accepted digest beat
    always @(posedge clk)
    begin
        if (rst_n && digest_valid && !digest_stall)
            sb.check_digest(digest);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one message beat, idling first at random, and hold it until accepted
    task automatic send_beat(input logic op_bit, input logic [7:0] data);
        sha1mh_pkg::msg_beat_t beat;
        beat.op        = op_bit;
        beat.data_byte = data;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            msg_valid <= 1'b0;
            @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg       <= beat;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        sb.note_beat(beat);
        items_sent++;
    endtask

    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++)
            send_beat(sha1mh_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
        send_beat(sha1mh_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
        messages_sent++;
    endtask

    // Pick idling for one phase: none, sender gaps, receiver stalls, both light
    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    initial
    begin
        int boundary_lens [3];
        int len;
        int sel;
        boundary_lens = '{55, 56, 64};
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message with an ignored byte on the finish beat
        send_beat(sha1mh_pkg::OP_FINISH, 8'hFF);
        // "abc"
        send_beat(sha1mh_pkg::OP_ABSORB, 8'h61);
        send_beat(sha1mh_pkg::OP_ABSORB, 8'h62);
        send_beat(sha1mh_pkg::OP_ABSORB, 8'h63);
        send_beat(sha1mh_pkg::OP_FINISH, 8'h00);
        // byte extremes
        send_beat(sha1mh_pkg::OP_ABSORB, 8'h00);
        send_beat(sha1mh_pkg::OP_ABSORB, 8'hFF);
        send_beat(sha1mh_pkg::OP_FINISH, 8'hA5);
        send_beat(sha1mh_pkg::OP_ABSORB, 8'hFF);
        send_beat(sha1mh_pkg::OP_FINISH, 8'h5A);
        messages_sent = 4;

        // Random: padding boundaries first, then mostly short messages
        for (int m = 0; m < 3; m++)
        begin
            set_idling(m);
            send_random_message(boundary_lens[m]);
        end
        while (items_sent < MIN_ITEMS)
        begin
            set_idling(messages_sent);
            sel = $urandom_range(0, 11);
            if (sel == 0)
                len = $urandom_range(65, 130);
            else if (sel <= 2)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(0, 20);
            send_random_message(len);
        end
        msg_valid <= 1'b0;

        // Drain the digest words still in flight
        recv_stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
